// File: rtl/brem_pkg.sv
// shared types, constants and helpers of the bad range extent mapper
`default_nettype none

package brem_pkg;

    localparam int FIELD_W      = 48;
    localparam int ALEN_W       = 49;
    localparam int COUNT_W      = 32;
    localparam int ENTRY_IDX_W  = 4;
    localparam int ENTRY_SLOTS  = 16;
    localparam int CFG_W        = 5;
    localparam int CFG_IDX_W    = 8;
    localparam int CFG_DATA_W   = 8;
    localparam int HIT_W        = 2;
    localparam int MASK_NARROW_W = 22;

    localparam int IN_TDATA_W   = 152;
    localparam int OUT_TDATA_W  = 328;

    // register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_COUNT = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LOG2   = 8'd1;

    localparam logic [CFG_W-1:0] BLOCK_LOG2_RESET = 5'd12;
    localparam logic [CFG_W-1:0] BLOCK_LOG2_MIN   = 5'd9;
    localparam logic [CFG_W-1:0] BLOCK_LOG2_MAX   = 5'd21;

    // input item kinds
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // result kinds
    localparam logic [HIT_W-1:0] HIT_NONE        = 2'd0;
    localparam logic [HIT_W-1:0] HIT_RANGE       = 2'd1;
    localparam logic [HIT_W-1:0] HIT_EMPTY_TABLE = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic [FIELD_W-1:0] phys;
        logic [FIELD_W-1:0] logical;
        logic [FIELD_W-1:0] length;
    } ext_entry_t;

    // walk slot that travels beside the memory read
    typedef struct packed {
        logic                   live;
        logic                   tail;
        logic [ENTRY_IDX_W-1:0] idx;
    } tag_t;

    // bad range under test, fixed for the whole walk
    typedef struct packed {
        logic [FIELD_W-1:0] start;
        logic [FIELD_W:0]   bend;
        logic               empty;
        logic [FIELD_W-1:0] bmask;
    } query_t;

    typedef struct packed {
        logic [ENTRY_IDX_W-1:0] extent_index;
        logic [FIELD_W-1:0]     phys_start;
        logic [FIELD_W-1:0]     mapped_start;
        logic [FIELD_W-1:0]     match_length;
        logic [FIELD_W-1:0]     aligned_phys_start;
        logic [FIELD_W-1:0]     aligned_logical_start;
        logic [ALEN_W-1:0]      aligned_length;
        logic [COUNT_W-1:0]     total_found;
        logic [HIT_W-1:0]       hit;
        logic                   last;
    } result_t;

    typedef struct packed {
        logic    ovl;
        logic    tail;
        result_t res;
    } pipe_out_t;

    // word layouts, last declared field in the lowest bits
    typedef struct packed {
        logic [3:0]             pad;
        logic [FIELD_W-1:0]     range_length;
        logic [FIELD_W-1:0]     logical_start;
        logic [FIELD_W-1:0]     start_offset;
        logic [ENTRY_IDX_W-1:0] entry_index;
    } in_data_t;

    typedef struct packed {
        logic [2:0]             pad;
        logic [COUNT_W-1:0]     total_found;
        logic [ALEN_W-1:0]      aligned_length;
        logic [FIELD_W-1:0]     aligned_logical_start;
        logic [FIELD_W-1:0]     aligned_phys_start;
        logic [FIELD_W-1:0]     match_length;
        logic [FIELD_W-1:0]     mapped_start;
        logic [FIELD_W-1:0]     phys_start;
        logic [ENTRY_IDX_W-1:0] extent_index;
    } out_data_t;

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
        return (v == {COUNT_W{1'b1}}) ? v : v + 1'b1;
    endfunction

endpackage

`default_nettype wire

// File: rtl/brem_ext_mem.sv
// extent memory, one write port and one registered read port
`default_nettype none

module brem_ext_mem #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  wire                  aclk,
    input  wire                  wr_en,
    input  wire [ADDR_W-1:0]     wr_addr,
    input  brem_pkg::ext_entry_t wr_data,
    input  wire                  rd_en,
    input  wire [ADDR_W-1:0]     rd_addr,
    output brem_pkg::ext_entry_t rd_data
);

    brem_pkg::ext_entry_t mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/brem_overlap_pipe.sv
// four stage overlap, clip and block widening pipeline behind the extent memory
`default_nettype none

module brem_overlap_pipe #(
    parameter int WRAP_BITS = 48
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  adv,
    input  brem_pkg::tag_t       tag_in,
    input  brem_pkg::ext_entry_t entry,
    input  brem_pkg::query_t     query,
    output brem_pkg::pipe_out_t  pipe_q
);

    localparam int FW = brem_pkg::FIELD_W;
    localparam logic [FW-1:0] WRAP_MASK = {FW{1'b1}} >> (FW - WRAP_BITS);

    brem_pkg::tag_t tag0_reg, tag1_reg, tag2_reg, tag3_reg;
    logic           ovl2_reg, ovl3_reg;

    logic [FW-1:0]  ob1_reg, delta1_reg;
    logic [FW:0]    oend1_reg;
    logic           olz1_reg;

    logic [FW-1:0]  beg2_reg, delta2_reg;
    logic [FW:0]    lim2_reg;

    logic [FW-1:0]  beg3_reg, mlen3_reg, mapped3_reg;

    logic [FW:0]    oend_c, lim_c, mlen_wide_c, al_c;
    logic [FW-1:0]  beg_c, mapped_c, mis_c;
    logic           ovl_c;

    always_comb begin
        oend_c      = {1'b0, entry.phys} + {1'b0, entry.length} - 1'b1;
        ovl_c       = tag1_reg.live && !olz1_reg && !query.empty
                      && !({1'b0, query.start} > oend1_reg)
                      && !({1'b0, ob1_reg} > query.bend);
        beg_c       = (query.start > ob1_reg) ? query.start : ob1_reg;
        lim_c       = (query.bend < oend1_reg) ? query.bend : oend1_reg;
        mlen_wide_c = lim2_reg - {1'b0, beg2_reg} + 1'b1;
        mapped_c    = (beg2_reg + delta2_reg) & WRAP_MASK;
        mis_c       = mapped3_reg & query.bmask;
        // round up to whole blocks: add the mask, then clear the low bits
        al_c        = ({1'b0, mlen3_reg} + {1'b0, mis_c} + {1'b0, query.bmask})
                      & ~{1'b0, query.bmask};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag0_reg    <= '0;
            tag1_reg    <= '0;
            tag2_reg    <= '0;
            tag3_reg    <= '0;
            ovl2_reg    <= 1'b0;
            ovl3_reg    <= 1'b0;
            pipe_q.ovl  <= 1'b0;
            pipe_q.tail <= 1'b0;
        end else if (adv) begin
            tag0_reg    <= tag_in;
            tag1_reg    <= tag0_reg;
            tag2_reg    <= tag1_reg;
            tag3_reg    <= tag2_reg;
            ovl2_reg    <= ovl_c;
            ovl3_reg    <= ovl2_reg;
            pipe_q.ovl  <= ovl3_reg;
            pipe_q.tail <= tag3_reg.tail;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ob1_reg    <= entry.phys;
            oend1_reg  <= oend_c;
            delta1_reg <= entry.logical - entry.phys;
            olz1_reg   <= (entry.length == '0);

            beg2_reg   <= beg_c;
            lim2_reg   <= lim_c;
            delta2_reg <= delta1_reg;

            beg3_reg    <= beg2_reg;
            mlen3_reg   <= mlen_wide_c[FW-1:0];
            mapped3_reg <= mapped_c;

            pipe_q.res.extent_index          <= tag3_reg.idx;
            pipe_q.res.phys_start            <= beg3_reg;
            pipe_q.res.mapped_start          <= mapped3_reg;
            pipe_q.res.match_length          <= mlen3_reg;
            pipe_q.res.aligned_phys_start    <= (beg3_reg - mis_c) & WRAP_MASK;
            pipe_q.res.aligned_logical_start <= mapped3_reg & ~query.bmask;
            pipe_q.res.aligned_length        <= al_c;
            pipe_q.res.total_found           <= '0;
            pipe_q.res.hit                   <= brem_pkg::HIT_NONE;
            pipe_q.res.last                  <= 1'b0;
        end
    end

endmodule

`default_nettype wire

// File: rtl/bad_range_extent_mapper_unit.sv
// top level of the bad range extent mapper: control, hit count and result words
`default_nettype none

// Maps bad physical byte ranges onto the extents of a file. Load words
// (s_tuser 0) write one extent entry and are answered by a single ack word.
// Query words (s_tuser 1) bring one bad range; the block reads entries 0 to
// n-1 of the extent memory, n being extent_count capped at MAX_EXTENTS, one
// entry per cycle unless the output stalls, and every overlapping entry
// yields one result word in ascending entry order, the final one marked by
// m_tlast. A query that finds nothing gives one word with m_tuser 0, and a
// query with no extents in use gives one word with m_tuser 2. The single
// read port of the extent memory sets the walk rate. One item is in work at
// a time; a finished word in the output register does not keep the next
// item from being accepted. The extent memory is not cleared at reset and
// an entry must be loaded before a query walks over it. Configuration
// writes are taken at any time on the cfg channel but must only be issued
// while the block is idle.
module bad_range_extent_mapper_unit #(
    parameter int MAX_EXTENTS = 16,
    parameter int ADDR_BITS   = 48
) (
    input  wire         aclk,
    input  wire         aresetn,

    input  wire         s_tvalid,
    output logic        s_tready,
    // entry_index[3:0], start_offset[51:4], logical_start[99:52],
    // range_length[147:100], zero pad[151:148]
    input  wire [151:0] s_tdata,
    // mode
    input  wire         s_tuser,
    // last_range
    input  wire         s_tlast,

    output logic        m_tvalid,
    input  wire         m_tready,
    // extent_index[3:0], phys_start[51:4], mapped_start[99:52],
    // match_length[147:100], aligned_phys_start[195:148],
    // aligned_logical_start[243:196], aligned_length[292:244],
    // total_found[324:293], zero pad[327:325]
    output logic [327:0] m_tdata,
    // hit
    output logic [1:0]  m_tuser,
    // last
    output logic        m_tlast,

    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire [7:0]   cfg_index,
    input  wire [7:0]   cfg_wdata
);

    localparam int IDX_W     = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
    localparam int WRAP_BITS = (ADDR_BITS < brem_pkg::FIELD_W) ? ADDR_BITS
                                                               : brem_pkg::FIELD_W;
    localparam int CW        = brem_pkg::CFG_W;

    brem_pkg::state_t state_reg, state_next;

    // configuration registers
    logic [CW-1:0] ext_count_reg;
    logic [CW-1:0] block_log2_reg;

    // item context
    logic                             mode_reg;
    logic [brem_pkg::ENTRY_IDX_W-1:0] idx_reg;
    logic                             last_range_reg;
    logic [CW-1:0]                    n_reg;
    logic [CW-1:0]                    walk_reg;
    brem_pkg::query_t                 query_reg;

    logic [brem_pkg::COUNT_W-1:0] hit_cnt_reg, hit_cnt_next;

    // pending hit, held until we know whether another one follows
    brem_pkg::result_t hold_reg, hold_next;
    logic              hold_valid_reg, hold_valid_next;

    brem_pkg::result_t out_reg;
    logic              out_valid_reg;

    brem_pkg::in_data_t   in_d;
    brem_pkg::out_data_t  out_d;
    brem_pkg::ext_entry_t wr_entry, rd_entry;
    brem_pkg::tag_t       tag_c;
    brem_pkg::pipe_out_t  pipe_q;
    brem_pkg::result_t    push_word, new_hit;

    logic              accept, cfg_write, adv, mem_wr, push;
    logic              issue, resp_push;
    logic [CW-1:0]     n_c, lg_c;
    logic [brem_pkg::MASK_NARROW_W-1:0] bmask_narrow;
    logic [IDX_W-1:0]  load_addr_lut [brem_pkg::ENTRY_SLOTS];
    logic [IDX_W-1:0]  rd_addr;

    assign in_d      = s_tdata;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    // whole pipeline and walk move together whenever the output slot frees
    assign adv = !out_valid_reg || m_tready;

    // entry_index wraps at the table depth
    for (genvar g = 0; g < brem_pkg::ENTRY_SLOTS; g++) begin : g_load_addr
        assign load_addr_lut[g] = IDX_W'(g % MAX_EXTENTS);
    end

    // ------------------------------------------------------------ config
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ext_count_reg  <= '0;
            block_log2_reg <= brem_pkg::BLOCK_LOG2_RESET;
        end else if (cfg_write) begin
            case (cfg_index)
                brem_pkg::CFG_EXTENT_COUNT: ext_count_reg  <= cfg_wdata[CW-1:0];
                brem_pkg::CFG_BLOCK_LOG2:   block_log2_reg <= cfg_wdata[CW-1:0];
                default: ;
            endcase
        end
    end

    // entries to walk, capped at the table depth
    assign n_c = (32'(ext_count_reg) > MAX_EXTENTS) ? CW'(MAX_EXTENTS) : ext_count_reg;

    // block size clamped into the supported range
    always_comb begin
        if (block_log2_reg < brem_pkg::BLOCK_LOG2_MIN) begin
            lg_c = brem_pkg::BLOCK_LOG2_MIN;
        end else if (block_log2_reg > brem_pkg::BLOCK_LOG2_MAX) begin
            lg_c = brem_pkg::BLOCK_LOG2_MAX;
        end else begin
            lg_c = block_log2_reg;
        end
    end

    assign bmask_narrow = ~({brem_pkg::MASK_NARROW_W{1'b1}} << lg_c);

    // ------------------------------------------------------------ item capture
    always_ff @(posedge aclk) begin
        if (accept) begin
            mode_reg        <= s_tuser;
            idx_reg         <= in_d.entry_index;
            last_range_reg  <= s_tlast;
            n_reg           <= n_c;
            query_reg.start <= in_d.start_offset;
            query_reg.bend  <= {1'b0, in_d.start_offset} + {1'b0, in_d.range_length}
                               - 1'b1;
            query_reg.empty <= (in_d.range_length == '0);
            query_reg.bmask <= {{(brem_pkg::FIELD_W - brem_pkg::MASK_NARROW_W){1'b0}},
                                bmask_narrow};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            walk_reg <= '0;
        end else if (accept) begin
            walk_reg <= '0;
        end else if (issue && adv) begin
            walk_reg <= walk_reg + 1'b1;
        end
    end

    // ------------------------------------------------------------ control fsm
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= brem_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            brem_pkg::ST_IDLE: begin
                if (accept) begin
                    if (s_tuser == brem_pkg::MODE_LOAD || n_c == '0) begin
                        state_next = brem_pkg::ST_RESP;
                    end else begin
                        state_next = brem_pkg::ST_WALK;
                    end
                end
            end
            brem_pkg::ST_WALK: begin
                // the slot after the last entry is the end marker
                if (adv && walk_reg == n_reg) begin
                    state_next = brem_pkg::ST_DRAIN;
                end
            end
            brem_pkg::ST_DRAIN: begin
                if (adv && pipe_q.tail) begin
                    state_next = brem_pkg::ST_IDLE;
                end
            end
            brem_pkg::ST_RESP: begin
                if (adv) begin
                    state_next = brem_pkg::ST_IDLE;
                end
            end
            default: state_next = brem_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready  = 1'b0;
        issue     = 1'b0;
        resp_push = 1'b0;
        case (state_reg)
            brem_pkg::ST_IDLE:  s_tready  = 1'b1;
            brem_pkg::ST_WALK:  issue     = 1'b1;
            brem_pkg::ST_DRAIN: ;
            brem_pkg::ST_RESP:  resp_push = adv;
            default: ;
        endcase
    end

    always_comb begin
        tag_c.live = issue && (walk_reg != n_reg);
        tag_c.tail = issue && (walk_reg == n_reg);
        tag_c.idx  = walk_reg[brem_pkg::ENTRY_IDX_W-1:0];
    end

    // ------------------------------------------------------------ extent memory
    assign mem_wr           = accept && (s_tuser == brem_pkg::MODE_LOAD);
    assign wr_entry.phys    = in_d.start_offset;
    assign wr_entry.logical = in_d.logical_start;
    assign wr_entry.length  = in_d.range_length;
    assign rd_addr          = IDX_W'(walk_reg);

    brem_ext_mem #(
        .DEPTH  (MAX_EXTENTS),
        .ADDR_W (IDX_W)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr),
        .wr_addr (load_addr_lut[in_d.entry_index]),
        .wr_data (wr_entry),
        .rd_en   (adv),
        .rd_addr (rd_addr),
        .rd_data (rd_entry)
    );

    brem_overlap_pipe #(
        .WRAP_BITS (WRAP_BITS)
    ) u_pipe (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv),
        .tag_in  (tag_c),
        .entry   (rd_entry),
        .query   (query_reg),
        .pipe_q  (pipe_q)
    );

    // ------------------------------------------------------------ result words
    always_comb begin
        push            = 1'b0;
        push_word       = '0;
        hit_cnt_next    = hit_cnt_reg;
        hold_next       = hold_reg;
        hold_valid_next = hold_valid_reg;

        new_hit             = pipe_q.res;
        new_hit.total_found = brem_pkg::sat_inc(hit_cnt_reg);
        new_hit.hit         = brem_pkg::HIT_RANGE;
        new_hit.last        = 1'b0;

        if (resp_push) begin
            push           = 1'b1;
            push_word.last = 1'b1;
            if (mode_reg == brem_pkg::MODE_LOAD) begin
                // load ack
                push_word.extent_index = idx_reg;
                push_word.hit          = brem_pkg::HIT_NONE;
            end else begin
                // no extents in use: count the query itself
                push_word.total_found = brem_pkg::sat_inc(hit_cnt_reg);
                push_word.hit         = brem_pkg::HIT_EMPTY_TABLE;
                hit_cnt_next          = last_range_reg ? '0
                                        : brem_pkg::sat_inc(hit_cnt_reg);
            end
        end else if (adv && pipe_q.ovl) begin
            hit_cnt_next    = new_hit.total_found;
            hold_next       = new_hit;
            hold_valid_next = 1'b1;
            if (hold_valid_reg) begin
                push      = 1'b1;
                push_word = hold_reg;
            end
        end else if (adv && pipe_q.tail) begin
            push            = 1'b1;
            hold_valid_next = 1'b0;
            if (hold_valid_reg) begin
                push_word      = hold_reg;
                push_word.last = 1'b1;
            end else begin
                // walk found no overlap
                push_word.total_found = hit_cnt_reg;
                push_word.hit         = brem_pkg::HIT_NONE;
                push_word.last        = 1'b1;
            end
            if (last_range_reg) begin
                hit_cnt_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_cnt_reg    <= '0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            hit_cnt_reg    <= hit_cnt_next;
            hold_valid_reg <= hold_valid_next;
            if (push) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        hold_reg <= hold_next;
        if (push) begin
            out_reg <= push_word;
        end
    end

    always_comb begin
        out_d.pad                   = '0;
        out_d.total_found           = out_reg.total_found;
        out_d.aligned_length        = out_reg.aligned_length;
        out_d.aligned_logical_start = out_reg.aligned_logical_start;
        out_d.aligned_phys_start    = out_reg.aligned_phys_start;
        out_d.match_length          = out_reg.match_length;
        out_d.mapped_start          = out_reg.mapped_start;
        out_d.phys_start            = out_reg.phys_start;
        out_d.extent_index          = out_reg.extent_index;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_d;
    assign m_tuser  = out_reg.hit;
    assign m_tlast  = out_reg.last;

endmodule

`default_nettype wire

// File: rtl/brem_checker.sv
// port level checks of the bad range extent mapper and their bind
`default_nettype none

module brem_checker (
    input wire         aclk,
    input wire         aresetn,
    input wire         m_tvalid,
    input wire         m_tready,
    input wire [327:0] m_tdata,
    input wire [1:0]   m_tuser,
    input wire         m_tlast
);

    brem_pkg::out_data_t od;
    assign od = m_tdata;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
                                  && $stable(m_tuser) && $stable(m_tlast))
        else $error("result word changed while stalled");

    a_empty_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == brem_pkg::HIT_EMPTY_TABLE
            |-> m_tlast && od.total_found != '0)
        else $error("empty table result not a single counted word");

    a_none_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == brem_pkg::HIT_NONE |-> m_tlast)
        else $error("no-hit word not marked last");

    a_range_counted: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == brem_pkg::HIT_RANGE
            |-> od.match_length != '0 && od.total_found != '0)
        else $error("overlap word with empty range or zero count");

    a_range_widened: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == brem_pkg::HIT_RANGE
            |-> od.aligned_length >= {1'b0, od.match_length})
        else $error("widened length below overlap length");

endmodule

bind bad_range_extent_mapper_unit brem_checker u_brem_checker (.*);

`default_nettype wire
